// ===== src/best_fit_bin_packer_assert.svh =====
// Assertion macros for the best-fit bin packer checker.
// Used by the checker module only; needs no other file.
`ifndef BEST_FIT_BIN_PACKER_ASSERT_SVH
`define BEST_FIT_BIN_PACKER_ASSERT_SVH

// check a property on every rising clock edge outside reset
`define BFBP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("best_fit_bin_packer: property failed");

// check that a condition implies another in the same cycle
`define BFBP_ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("best_fit_bin_packer: implication failed");

`endif

// ===== src/bfbp_pkg.sv =====
// Shared types and constants of the best-fit bin packer.
// No dependencies.
package bfbp_pkg;

	localparam int SIZE_W   = 17;
	localparam int INDEX_W  = 8;
	localparam int STATUS_W = 2;

	typedef logic [SIZE_W-1:0]   size_t;
	typedef logic [INDEX_W-1:0]  index_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t STATUS_OK       = 2'd0;
	localparam status_t STATUS_OVERSIZE = 2'd1;
	localparam status_t STATUS_FULL     = 2'd2;

	localparam size_t CAP_RESET = 17'h10000;

endpackage

// ===== src/bfbp_if.sv =====
// Valid/ready channel interfaces for items and results.
// Depends on bfbp_pkg.
interface bfbp_item_if;
	import bfbp_pkg::*;

	logic  valid;
	logic  ready;
	size_t item_size;
	logic  new_list;

	modport source (output valid, output item_size, output new_list, input ready);
	modport sink (input valid, input item_size, input new_list, output ready);
endinterface

interface bfbp_result_if;
	import bfbp_pkg::*;

	logic    valid;
	logic    ready;
	index_t  bin_index;
	logic    bin_opened;
	size_t   space_left;
	status_t status;

	modport source (output valid, output bin_index, output bin_opened,
		output space_left, output status, input ready);
	modport sink (input valid, input bin_index, input bin_opened,
		input space_left, input status, output ready);
endinterface

// ===== src/best_fit_bin_packer.sv =====
// Top level of the online best-fit bin packer: configuration port and assembly.
// Depends on bfbp_pkg, bfbp_if, bfbp_mem and bfbp_ctrl.
//
// Usage:
//   items carries item_size and new_list; results returns bin_index,
//   bin_opened, space_left and status, one result per item, in order.
//   The APB port holds bin_capacity at byte address 0; a write lands at the
//   edge where psel, penable, pwrite and pready are high. Write it only idle.
//   An item is taken only while no other item is in work. The table scan
//   reads one open bin per cycle through the memory read port, then the
//   result is registered in the output register; an oversize item skips
//   the scan and goes straight to the output register.
//   A result waits in an output register while results.ready is low; the
//   next item is still taken and scanned, and its result holds back until
//   the register frees.
//   Reset empties the table (no open bins) and sets bin_capacity to 65536;
//   the memory needs no clearing pass since only written entries are read.
module best_fit_bin_packer #(
	parameter int MAX_BINS = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	bfbp_item_if.sink     items,
	bfbp_result_if.source results,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import bfbp_pkg::*;

	localparam int AW = $clog2(MAX_BINS);
	localparam int CW = $clog2(MAX_BINS + 1);
	localparam logic REG_BIN_CAPACITY = 1'b0;

	size_t         cap_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	size_t         mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	size_t         mem_rdata;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BIN_CAPACITY) ? 32'(cap_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_BIN_CAPACITY) begin
			cap_q <= pwdata[SIZE_W-1:0];
		end
	end

	bfbp_mem #(
		.DEPTH (MAX_BINS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	bfbp_ctrl #(
		.MAX_BINS (MAX_BINS),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.bin_capacity (cap_q),
		.items        (items),
		.results      (results),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

endmodule

// ===== src/bfbp_mem.sv =====
// Free-space table: one write port, one read port with registered data.
// Depends on bfbp_pkg.
module bfbp_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  bfbp_pkg::size_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output bfbp_pkg::size_t rdata
);
	import bfbp_pkg::*;

	size_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/bfbp_ctrl.sv =====
// Scan sequencer: reads every open bin, keeps the tightest fit, writes back.
// Depends on bfbp_pkg, bfbp_if and drives the bfbp_mem ports.
module bfbp_ctrl #(
	parameter int MAX_BINS = 256,
	parameter int AW       = 8,
	parameter int CW       = 9
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bfbp_pkg::size_t bin_capacity,
	bfbp_item_if.sink       items,
	bfbp_result_if.source   results,
	output logic            mem_we,
	output logic [AW-1:0]   mem_waddr,
	output bfbp_pkg::size_t mem_wdata,
	output logic            mem_re,
	output logic [AW-1:0]   mem_raddr,
	input  bfbp_pkg::size_t mem_rdata
);
	import bfbp_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam int XW = (AW > INDEX_W) ? AW : INDEX_W;
	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_BINS);

	logic [1:0]    state_q;
	size_t         size_q;
	logic          over_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic          rvalid_s1;
	logic [AW-1:0] ridx_s1;
	logic          have_q;
	size_t         best_q;
	logic [AW-1:0] pick_q;

	logic          out_valid_q;
	index_t        bin_index_q;
	logic          bin_opened_q;
	size_t         space_left_q;
	status_t       status_q;

	logic          out_free;
	logic          fits;
	logic          room;
	logic [XW-1:0] idx_ext;

	assign items.ready = (state_q == ST_IDLE);
	assign out_free    = !out_valid_q || results.ready;
	assign fits        = rvalid_s1 && (mem_rdata >= size_q) && (!have_q || mem_rdata < best_q);
	assign room        = (count_q != FULL_COUNT);

	assign mem_re    = (state_q == ST_SCAN) && (rd_idx_q < count_q);
	assign mem_raddr = rd_idx_q[AW-1:0];
	assign mem_we    = (state_q == ST_DONE) && out_free && !over_q && (have_q || room);
	assign mem_waddr = have_q ? pick_q : count_q[AW-1:0];
	assign mem_wdata = have_q ? size_t'(best_q - size_q) : size_t'(bin_capacity - size_q);
	assign idx_ext   = have_q ? XW'(pick_q) : XW'(count_q[AW-1:0]);

	assign results.valid      = out_valid_q;
	assign results.bin_index  = bin_index_q;
	assign results.bin_opened = bin_opened_q;
	assign results.space_left = space_left_q;
	assign results.status     = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			rvalid_s1   <= 1'b0;
			have_q      <= 1'b0;
			over_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (state_q == ST_DONE && out_free) || (out_valid_q && !results.ready);
			rvalid_s1 <= mem_re;
			unique case (state_q)
				ST_IDLE: begin
					if (items.valid) begin
						have_q   <= 1'b0;
						rd_idx_q <= '0;
						over_q   <= (items.item_size > bin_capacity);
						if (items.new_list) begin
							count_q <= '0;
						end
						state_q <= (items.item_size > bin_capacity) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (mem_re) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end else begin
						state_q <= ST_DONE;
					end
					if (fits) begin
						have_q <= 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (!over_q && !have_q && room) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && items.valid) begin
			size_q <= items.item_size;
		end
		if (state_q == ST_SCAN) begin
			ridx_s1 <= rd_idx_q[AW-1:0];
			if (fits) begin
				best_q <= mem_rdata;
				pick_q <= ridx_s1;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			if (over_q) begin
				bin_index_q  <= '0;
				bin_opened_q <= 1'b0;
				space_left_q <= '0;
				status_q     <= STATUS_OVERSIZE;
			end else if (have_q || room) begin
				bin_index_q  <= idx_ext[INDEX_W-1:0];
				bin_opened_q <= !have_q;
				space_left_q <= mem_wdata;
				status_q     <= STATUS_OK;
			end else begin
				bin_index_q  <= '0;
				bin_opened_q <= 1'b0;
				space_left_q <= '0;
				status_q     <= STATUS_FULL;
			end
		end
	end

endmodule

// ===== src/bfbp_chk.sv =====
// Port-level checker for the best-fit bin packer, bound to the top level.
// Depends on bfbp_pkg and best_fit_bin_packer_assert.svh.
`include "best_fit_bin_packer_assert.svh"

module bfbp_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input bfbp_pkg::index_t  bin_index,
	input logic              bin_opened,
	input bfbp_pkg::size_t   space_left,
	input bfbp_pkg::status_t status
);
	import bfbp_pkg::*;

	`BFBP_ASSERT(a_result_held, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(bin_index) && $stable(space_left) && $stable(status))
	`BFBP_ASSERT_IMPLY(a_error_zero, clk, arst_n, out_valid && status != STATUS_OK, bin_index == '0 && !bin_opened && space_left == '0)
	`BFBP_ASSERT_IMPLY(a_open_ok, clk, arst_n, out_valid && bin_opened, status == STATUS_OK)

endmodule

bind best_fit_bin_packer bfbp_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.bin_index  (results.bin_index),
	.bin_opened (results.bin_opened),
	.space_left (results.space_left),
	.status     (results.status)
);
